### hdl/mts_pkg.sv
// shared types and constants of the masked topological sort block
package mts_pkg;

    localparam int ID_W   = 12;
    localparam int KIND_W = 3;
    localparam int CNT_W  = 13;

    localparam logic [KIND_W-1:0] KIND_ADD   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MARK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_EDGE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RUN   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FETCH = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd5;

    typedef enum logic [4:0] {
        ST_RESET_CLR,
        ST_IDLE,
        ST_CLR_ITEM,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_EDGE_CHK,
        ST_EDGE_FILL,
        ST_EDGE_WR,
        ST_FETCH_RD,
        ST_FETCH_DATA,
        ST_Z_RD,
        ST_Z_WR,
        ST_C_RD,
        ST_U,
        ST_LO,
        ST_HI,
        ST_E,
        ST_D,
        ST_W,
        ST_S_RD,
        ST_S_M,
        ST_S_W,
        ST_P_RD,
        ST_RESP
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_ACCEPT,
        OP_ADD_RD,
        OP_ADD_WR,
        OP_MARK_RD,
        OP_MARK_WR,
        OP_EDGE_CHK,
        OP_EDGE_FILL,
        OP_EDGE_WR,
        OP_FETCH_RD,
        OP_FETCH_DATA,
        OP_Z_RD,
        OP_Z_WR,
        OP_C_RD,
        OP_U,
        OP_LO,
        OP_HI,
        OP_E,
        OP_D,
        OP_W,
        OP_S_RD,
        OP_S_M,
        OP_S_W,
        OP_P_RD,
        OP_RESP
    } op_t;

    typedef struct packed {
        op_t  op;
        logic pop;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic clr_last;
        logic edge_err;
        logic edge_fill;
        logic fill_last;
        logic i_end;
        logic range_empty;
        logic u_is_last;
        logic e_end;
        logic head_end;
    } sts_t;

endpackage

### hdl/mts_ifs.sv
// handshake channel interfaces of the masked topological sort block
interface mts_item_if;
    logic                       valid;
    logic                       ready;
    logic [mts_pkg::KIND_W-1:0] kind;
    logic [mts_pkg::ID_W-1:0]   node;
    logic [mts_pkg::ID_W-1:0]   edge_dest;
    logic [mts_pkg::ID_W-1:0]   position;
    modport source (output valid, kind, node, edge_dest, position, input ready);
    modport sink (input valid, kind, node, edge_dest, position, output ready);
endinterface

interface mts_result_if;
    logic                      valid;
    logic                      ready;
    logic [mts_pkg::ID_W-1:0]  result_node;
    logic [mts_pkg::CNT_W-1:0] sorted_count;
    logic                      acyclic;
    logic                      error;
    modport source (output valid, result_node, sorted_count, acyclic, error, input ready);
    modport sink (input valid, result_node, sorted_count, acyclic, error, output ready);
endinterface

interface mts_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [mts_pkg::CNT_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

### hdl/mts_ctrl.sv
// controller state machine of the masked topological sort block
module mts_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    input  logic [mts_pkg::KIND_W-1:0] item_kind,
    output logic                       item_ready,
    input  mts_pkg::sts_t              sts,
    output mts_pkg::cmd_t              cmd
);
    import mts_pkg::*;

    state_t state_reg, state_next;
    logic   pop_reg, pop_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RESET_CLR;
            pop_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pop_reg   <= pop_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pop_next   = pop_reg;
        case (state_reg)
            ST_RESET_CLR: if (sts.clr_last) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    case (item_kind)
                        KIND_ADD:   state_next = ST_ADD_RD;
                        KIND_MARK:  state_next = ST_MARK_RD;
                        KIND_EDGE:  state_next = ST_EDGE_CHK;
                        KIND_RUN:   state_next = ST_Z_RD;
                        KIND_FETCH: state_next = ST_FETCH_RD;
                        KIND_CLEAR: state_next = ST_CLR_ITEM;
                        default:    state_next = ST_RESP;
                    endcase
                end
            end
            ST_CLR_ITEM:   if (sts.clr_last) state_next = ST_RESP;
            ST_ADD_RD:     state_next = ST_ADD_WR;
            ST_ADD_WR:     state_next = ST_RESP;
            ST_MARK_RD:    state_next = ST_MARK_WR;
            ST_MARK_WR:    state_next = ST_RESP;
            ST_EDGE_CHK:
            begin
                if (sts.edge_err)
                    state_next = ST_RESP;
                else if (sts.edge_fill)
                    state_next = ST_EDGE_FILL;
                else
                    state_next = ST_EDGE_WR;
            end
            ST_EDGE_FILL:  if (sts.fill_last) state_next = ST_EDGE_WR;
            ST_EDGE_WR:    state_next = ST_RESP;
            ST_FETCH_RD:   state_next = ST_FETCH_DATA;
            ST_FETCH_DATA: state_next = ST_RESP;
            ST_Z_RD:       state_next = sts.i_end ? ST_C_RD : ST_Z_WR;
            ST_Z_WR:       state_next = ST_Z_RD;
            ST_C_RD:
            begin
                pop_next   = 1'b0;
                state_next = sts.i_end ? ST_S_RD : ST_U;
            end
            ST_U:
            begin
                if (sts.range_empty)
                    state_next = pop_reg ? ST_P_RD : ST_C_RD;
                else
                    state_next = ST_LO;
            end
            ST_LO:         state_next = sts.u_is_last ? ST_E : ST_HI;
            ST_HI:         state_next = ST_E;
            ST_E:
            begin
                if (sts.e_end)
                    state_next = pop_reg ? ST_P_RD : ST_C_RD;
                else
                    state_next = ST_D;
            end
            ST_D:          state_next = ST_W;
            ST_W:          state_next = ST_E;
            ST_S_RD:       state_next = sts.i_end ? ST_P_RD : ST_S_M;
            ST_S_M:        state_next = ST_S_W;
            ST_S_W:        state_next = ST_S_RD;
            ST_P_RD:
            begin
                pop_next   = 1'b1;
                state_next = sts.head_end ? ST_RESP : ST_U;
            end
            ST_RESP:       if (sts.out_free) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.pop    = pop_reg;
        item_ready = 1'b0;
        case (state_reg)
            ST_RESET_CLR:  cmd.op = OP_CLEAR;
            ST_IDLE:
            begin
                item_ready = 1'b1;
                cmd.op     = item_valid ? OP_ACCEPT : OP_NONE;
            end
            ST_CLR_ITEM:   cmd.op = OP_CLEAR;
            ST_ADD_RD:     cmd.op = OP_ADD_RD;
            ST_ADD_WR:     cmd.op = OP_ADD_WR;
            ST_MARK_RD:    cmd.op = OP_MARK_RD;
            ST_MARK_WR:    cmd.op = OP_MARK_WR;
            ST_EDGE_CHK:   cmd.op = OP_EDGE_CHK;
            ST_EDGE_FILL:  cmd.op = OP_EDGE_FILL;
            ST_EDGE_WR:    cmd.op = OP_EDGE_WR;
            ST_FETCH_RD:   cmd.op = OP_FETCH_RD;
            ST_FETCH_DATA: cmd.op = OP_FETCH_DATA;
            ST_Z_RD:       cmd.op = OP_Z_RD;
            ST_Z_WR:       cmd.op = OP_Z_WR;
            ST_C_RD:       cmd.op = OP_C_RD;
            ST_U:          cmd.op = OP_U;
            ST_LO:         cmd.op = OP_LO;
            ST_HI:         cmd.op = OP_HI;
            ST_E:          cmd.op = OP_E;
            ST_D:          cmd.op = OP_D;
            ST_W:          cmd.op = OP_W;
            ST_S_RD:       cmd.op = OP_S_RD;
            ST_S_M:        cmd.op = OP_S_M;
            ST_S_W:        cmd.op = OP_S_W;
            ST_P_RD:       cmd.op = OP_P_RD;
            ST_RESP:       cmd.op = sts.out_free ? OP_RESP : OP_NONE;
            default:       cmd.op = OP_NONE;
        endcase
    end

    a_resp_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_RESP |-> sts.out_free)
        else $error("result loaded while output register full");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> state_reg != ST_IDLE)
        else $error("accepted beat did not start work");

endmodule

### hdl/mts_dp.sv
// datapath of the masked topological sort block: stores, counters, output register
module mts_dp #(
    parameter int MAX_NODES = 4096,
    parameter int MAX_EDGES = 65536
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mts_pkg::cmd_t              cmd,
    output mts_pkg::sts_t              sts,
    input  logic [mts_pkg::KIND_W-1:0] kind,
    input  logic [mts_pkg::ID_W-1:0]   node,
    input  logic [mts_pkg::ID_W-1:0]   edge_dest,
    input  logic [mts_pkg::ID_W-1:0]   position,
    input  logic                       cfg_valid,
    input  logic [mts_pkg::CNT_W-1:0]  cfg_data,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [mts_pkg::ID_W-1:0]   out_node,
    output logic [mts_pkg::CNT_W-1:0]  out_count,
    output logic                       out_acyclic,
    output logic                       out_error
);
    import mts_pkg::*;

    localparam int AW  = $clog2(MAX_NODES);
    localparam int LW  = $clog2(MAX_NODES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EW  = $clog2(MAX_EDGES + 1);

    // stores
    logic [ID_W-1:0] list_mem  [MAX_NODES];
    logic [1:0]      mark_mem  [MAX_NODES];   // bit 1 excluded, bit 0 member
    logic [EW-1:0]   deg_mem   [MAX_NODES];
    logic [ID_W-1:0] queue_mem [MAX_NODES];
    logic [EW-1:0]   start_mem [MAX_NODES + 1];
    logic [ID_W-1:0] edge_mem  [MAX_EDGES];

    logic [ID_W-1:0] list_rdata, queue_rdata, edge_rdata;
    logic [1:0]      mark_rdata;
    logic [EW-1:0]   deg_rdata, start_rdata;

    // control registers
    logic [CNT_W-1:0] node_count_reg;
    logic [LW-1:0]    list_length_reg;
    logic [EW-1:0]    edge_total_reg;
    logic [ID_W-1:0]  last_source_reg;
    logic             have_edges_reg;
    logic [LW-1:0]    order_count_reg;
    logic             acyclic_reg;
    logic [AW-1:0]    clr_reg;
    logic             out_valid_reg;

    // working registers
    logic [ID_W-1:0]   node_reg, dest_reg, pos_reg, u_reg, d_reg;
    logic [LW-1:0]     i_reg, head_reg, v_reg;
    logic [EW-1:0]     e_reg, hi_reg;
    logic [ID_W-1:0]   res_node_reg;
    logic              err_reg;
    logic [ID_W-1:0]   out_node_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic              out_acyclic_reg, out_error_reg;

    function automatic logic id_bad(input logic [ID_W-1:0] x, input logic [CNT_W-1:0] lim);
        id_bad = ({1'b0, x} >= lim) || (32'(x) >= MAX_NODES);
    endfunction

    logic [ID_W-1:0] u_src;
    logic            fetch_ok, cnt_ok, seed_ok, q_room, range_empty;

    assign u_src       = cmd.pop ? queue_rdata : list_rdata;
    assign range_empty = !have_edges_reg || (u_src > last_source_reg) ||
                         (32'(u_src) >= MAX_NODES);
    assign fetch_ok    = (32'(pos_reg) < 32'(order_count_reg)) &&
                         (32'(pos_reg) < MAX_NODES);
    assign cnt_ok      = (32'(d_reg) < MAX_NODES) && mark_rdata[0] && !mark_rdata[1];
    assign q_room      = 32'(order_count_reg) < MAX_NODES;
    assign seed_ok     = !mark_rdata[1] && (deg_rdata == '0) && q_room;

    always_comb
    begin
        sts.out_free    = !out_valid_reg || out_ready;
        sts.clr_last    = 32'(clr_reg) == MAX_NODES - 1;
        sts.edge_err    = id_bad(node_reg, node_count_reg) ||
                          id_bad(dest_reg, node_count_reg) ||
                          (32'(edge_total_reg) >= MAX_EDGES) ||
                          (have_edges_reg && (node_reg < last_source_reg));
        sts.edge_fill   = !have_edges_reg || (node_reg > last_source_reg);
        sts.fill_last   = v_reg == LW'(node_reg);
        sts.i_end       = i_reg == list_length_reg;
        sts.range_empty = range_empty;
        sts.u_is_last   = u_reg == last_source_reg;
        sts.e_end       = e_reg == hi_reg;
        sts.head_end    = head_reg == order_count_reg;
    end

    // memory port selection
    logic            list_re, list_we, mark_re, mark_we, deg_re, deg_we;
    logic            queue_re, queue_we, start_re, start_we, edge_re, edge_we;
    logic [AW-1:0]   list_ra, mark_ra, mark_wa, deg_ra, deg_wa, queue_ra, queue_wa;
    logic [LW-1:0]   start_ra, start_wa;
    logic [EAW-1:0]  edge_ra;
    logic [1:0]      mark_wd;
    logic [EW-1:0]   deg_wd;
    logic [ID_W-1:0] queue_wd;

    always_comb
    begin
        list_re  = 1'b0; list_ra  = i_reg[AW-1:0];
        list_we  = 1'b0;
        mark_re  = 1'b0; mark_ra  = AW'(node_reg);
        mark_we  = 1'b0; mark_wa  = AW'(node_reg); mark_wd = 2'b00;
        deg_re   = 1'b0; deg_ra   = AW'(edge_rdata);
        deg_we   = 1'b0; deg_wa   = AW'(d_reg);    deg_wd  = '0;
        queue_re = 1'b0; queue_ra = head_reg[AW-1:0];
        queue_we = 1'b0; queue_wa = order_count_reg[AW-1:0]; queue_wd = d_reg;
        start_re = 1'b0; start_ra = LW'(u_src);
        start_we = 1'b0; start_wa = v_reg;
        edge_re  = 1'b0; edge_ra  = e_reg[EAW-1:0];
        edge_we  = 1'b0;
        case (cmd.op)
            OP_CLEAR:
            begin
                mark_we = 1'b1;
                mark_wa = clr_reg;
            end
            OP_ADD_RD, OP_MARK_RD: mark_re = 1'b1;
            OP_ADD_WR:
            begin
                if (!(id_bad(node_reg, node_count_reg) || mark_rdata[0] ||
                      (32'(list_length_reg) >= MAX_NODES)))
                begin
                    list_we = 1'b1;
                    mark_we = 1'b1;
                    mark_wd = {mark_rdata[1], 1'b1};
                end
            end
            OP_MARK_WR:
            begin
                if (!id_bad(node_reg, node_count_reg))
                begin
                    mark_we = 1'b1;
                    mark_wd = {1'b1, mark_rdata[0]};
                end
            end
            OP_EDGE_FILL: start_we = 1'b1;
            OP_EDGE_WR:   edge_we  = 1'b1;
            OP_FETCH_RD:
            begin
                queue_re = 1'b1;
                queue_ra = AW'(pos_reg);
            end
            OP_Z_RD, OP_C_RD, OP_S_RD: list_re = !sts.i_end;
            OP_Z_WR:
            begin
                deg_we = 1'b1;
                deg_wa = AW'(list_rdata);
            end
            OP_U:  start_re = !range_empty;
            OP_LO:
            begin
                start_re = 1'b1;
                start_ra = LW'(u_reg) + LW'(1);
            end
            OP_E:  edge_re = !sts.e_end;
            OP_D:
            begin
                mark_re = 1'b1;
                mark_ra = AW'(edge_rdata);
                deg_re  = 1'b1;
            end
            OP_W:
            begin
                if (!cmd.pop)
                begin
                    deg_we = cnt_ok;
                    deg_wd = deg_rdata + EW'(1);
                end
                else if (cnt_ok && (deg_rdata != '0))
                begin
                    deg_we   = 1'b1;
                    deg_wd   = deg_rdata - EW'(1);
                    queue_we = (deg_rdata == EW'(1)) && q_room;
                end
            end
            OP_S_M:
            begin
                mark_re = 1'b1;
                mark_ra = AW'(list_rdata);
                deg_re  = 1'b1;
                deg_ra  = AW'(list_rdata);
            end
            OP_S_W:
            begin
                queue_we = seed_ok;
                queue_wd = u_reg;
            end
            OP_P_RD: queue_re = !sts.head_end;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (list_we)
            list_mem[list_length_reg[AW-1:0]] <= node_reg;
        if (list_re)
            list_rdata <= list_mem[list_ra];
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
            mark_mem[mark_wa] <= mark_wd;
        if (mark_re)
            mark_rdata <= mark_mem[mark_ra];
    end

    always_ff @(posedge clk)
    begin
        if (deg_we)
            deg_mem[deg_wa] <= deg_wd;
        if (deg_re)
            deg_rdata <= deg_mem[deg_ra];
    end

    always_ff @(posedge clk)
    begin
        if (queue_we)
            queue_mem[queue_wa] <= queue_wd;
        if (queue_re)
            queue_rdata <= queue_mem[queue_ra];
    end

    always_ff @(posedge clk)
    begin
        if (start_we)
            start_mem[start_wa] <= edge_total_reg;
        if (start_re)
            start_rdata <= start_mem[start_ra];
    end

    always_ff @(posedge clk)
    begin
        if (edge_we)
            edge_mem[edge_total_reg[EAW-1:0]] <= dest_reg;
        if (edge_re)
            edge_rdata <= edge_mem[edge_ra];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg  <= CNT_W'(4096);
            list_length_reg <= '0;
            edge_total_reg  <= '0;
            last_source_reg <= '0;
            have_edges_reg  <= 1'b0;
            order_count_reg <= '0;
            acyclic_reg     <= 1'b0;
            clr_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                node_count_reg <= cfg_data;
            if (cmd.op == OP_RESP)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (cmd.op)
                OP_CLEAR: clr_reg <= sts.clr_last ? '0 : clr_reg + AW'(1);
                OP_ACCEPT:
                begin
                    if (kind == KIND_RUN)
                        order_count_reg <= '0;
                    if (kind == KIND_CLEAR)
                    begin
                        list_length_reg <= '0;
                        edge_total_reg  <= '0;
                        last_source_reg <= '0;
                        have_edges_reg  <= 1'b0;
                        order_count_reg <= '0;
                        acyclic_reg     <= 1'b0;
                    end
                end
                OP_ADD_WR:   if (list_we) list_length_reg <= list_length_reg + LW'(1);
                OP_EDGE_CHK:
                begin
                    if (!sts.edge_err && sts.edge_fill)
                    begin
                        last_source_reg <= node_reg;
                        have_edges_reg  <= 1'b1;
                    end
                end
                OP_EDGE_WR:  edge_total_reg <= edge_total_reg + EW'(1);
                OP_W, OP_S_W: if (queue_we) order_count_reg <= order_count_reg + LW'(1);
                OP_P_RD:     if (sts.head_end) acyclic_reg <= order_count_reg == list_length_reg;
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_ACCEPT:
            begin
                node_reg     <= node;
                dest_reg     <= edge_dest;
                pos_reg      <= position;
                i_reg        <= '0;
                head_reg     <= '0;
                res_node_reg <= '0;
                err_reg      <= kind > KIND_CLEAR;
            end
            OP_ADD_WR:   if (!list_we) err_reg <= 1'b1;
            OP_MARK_WR:  if (!mark_we) err_reg <= 1'b1;
            OP_EDGE_CHK:
            begin
                if (sts.edge_err)
                    err_reg <= 1'b1;
                v_reg <= have_edges_reg ? LW'(last_source_reg) + LW'(1) : '0;
            end
            OP_EDGE_FILL: v_reg <= v_reg + LW'(1);
            OP_FETCH_RD:  if (!fetch_ok) err_reg <= 1'b1;
            OP_FETCH_DATA: if (fetch_ok) res_node_reg <= queue_rdata;
            OP_Z_RD, OP_C_RD: if (sts.i_end) i_reg <= '0;
            OP_Z_WR, OP_S_W:  i_reg <= i_reg + LW'(1);
            OP_U:
            begin
                u_reg <= u_src;
                if (range_empty && !cmd.pop)
                    i_reg <= i_reg + LW'(1);
            end
            OP_LO:
            begin
                e_reg  <= start_rdata;
                hi_reg <= edge_total_reg;
            end
            OP_HI: hi_reg <= start_rdata;
            OP_E:  if (sts.e_end && !cmd.pop) i_reg <= i_reg + LW'(1);
            OP_D:  d_reg <= edge_rdata;
            OP_W:  e_reg <= e_reg + EW'(1);
            OP_S_M: u_reg <= list_rdata;
            OP_P_RD: if (!sts.head_end) head_reg <= head_reg + LW'(1);
            OP_RESP:
            begin
                out_node_reg    <= res_node_reg;
                out_count_reg   <= CNT_W'(order_count_reg);
                out_acyclic_reg <= acyclic_reg;
                out_error_reg   <= err_reg;
            end
            default: ;
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign out_node    = out_node_reg;
    assign out_count   = out_count_reg;
    assign out_acyclic = out_acyclic_reg;
    assign out_error   = out_error_reg;

    a_order_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        order_count_reg <= list_length_reg)
        else $error("more nodes ordered than listed");

    a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(edge_total_reg) <= MAX_EDGES)
        else $error("edge store overrun");

    a_edge_grows_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_EDGE_WR |=> edge_total_reg == $past(edge_total_reg) + EW'(1))
        else $error("edge count not advanced by one");

endmodule

### hdl/masked_topological_sort_top.sv
// top level of the masked topological sort block
// channels: item (sink) carries kind/node/edge_dest/position beats, result
// (source) returns one beat per item, cfg (sink) writes node_count and is
// always ready; write it only while no item is in flight.
// an item is accepted only when the controller is idle; add, mark and fetch
// go through a read state and a write or data state to the response state
// that loads the result, and the next beat is taken back in idle, so no item
// is taken before the last one's result is loaded. an edge beat writes one
// start-index entry per source from after the previous source up to the new
// one; a rejected edge and an unused kind go straight to the response.
// a run zeroes the in-degree of each list node, counts in-degrees along
// the edges of each list node, seeds the queue and pops each ordered node
// to walk its edges; every step is paced by the single registered read port
// of each store. a clear item sweeps the mark store; after reset the same
// sweep runs before the first item is accepted; cfg writes are taken during it.
// results wait in an output register; a stalled receiver holds the block
// in its final step, the next item is accepted as soon as it is loaded.
module masked_topological_sort_top #(
    parameter int MAX_NODES = 4096,
    parameter int MAX_EDGES = 65536
) (
    input logic          clk,
    input logic          rst_n,
    mts_cfg_if.sink      cfg,
    mts_item_if.sink     item,
    mts_result_if.source result
);
    import mts_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic item_ready;

    assign cfg.ready  = 1'b1;
    assign item.ready = item_ready;

    mts_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_kind  (item.kind),
        .item_ready (item_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    mts_dp #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .kind        (item.kind),
        .node        (item.node),
        .edge_dest   (item.edge_dest),
        .position    (item.position),
        .cfg_valid   (cfg.valid),
        .cfg_data    (cfg.data),
        .out_ready   (result.ready),
        .out_valid   (result.valid),
        .out_node    (result.result_node),
        .out_count   (result.sorted_count),
        .out_acyclic (result.acyclic),
        .out_error   (result.error)
    );

endmodule
